>>> src/sde_pkg.sv
`default_nettype none
package sde_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int ALPHA_BITS  = 16;
  localparam int NUM_AXES    = 3;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int TIME_W      = 32;
  localparam int AVG_W       = 32;
  localparam int FRAC_W      = 16;

  localparam logic [CFG_W-1:0] ALPHA_RESET     = 16'd6554;
  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd120;
  localparam logic [CFG_W-1:0] HOLD_RESET      = 16'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_X     = 3'd0,
    CFG_ALPHA_Y     = 3'd1,
    CFG_ALPHA_Z     = 3'd2,
    CFG_THRESHOLD_X = 3'd3,
    CFG_THRESHOLD_Y = 3'd4,
    CFG_THRESHOLD_Z = 3'd5,
    CFG_HOLD        = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic shaken_x;
    logic shaken_y;
    logic shaken_z;
    logic shaken_any;
    logic raw_any;
  } sde_result_t;

endpackage
`default_nettype wire

>>> src/sde_lane.sv
`default_nettype none
module sde_lane (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               step_i,
  input  wire logic [sde_pkg::SAMPLE_BITS-1:0]    sample_i,
  input  wire logic [sde_pkg::CFG_W-1:0]          alpha_i,
  input  wire logic [sde_pkg::CFG_W-1:0]          threshold_i,
  output logic                                    raw_o
);
  import sde_pkg::*;

  localparam int SUM_W = ALPHA_BITS + AVG_W + 2;
  localparam logic [ALPHA_BITS:0] ALPHA_ONE = {1'b1, {ALPHA_BITS{1'b0}}};

  logic [SAMPLE_BITS-1:0]          last_q, last_d;
  logic [AVG_W-1:0]                avg_q, avg_d;
  logic [SAMPLE_BITS-1:0]          diff;
  logic [SAMPLE_BITS-1:0]          mag;
  logic [ALPHA_BITS-1:0]           alpha;
  logic [ALPHA_BITS:0]             alpha_inv;
  logic [ALPHA_BITS+SAMPLE_BITS-1:0] prod_fresh;
  logic [ALPHA_BITS+AVG_W:0]       prod_old;
  logic [SUM_W-1:0]                sum;

  always_comb begin
    diff       = last_q - sample_i;
    // most negative value maps onto itself, read unsigned as the full magnitude
    mag        = diff[SAMPLE_BITS-1] ? (~diff + 1'b1) : diff;
    alpha      = ALPHA_BITS'(alpha_i);
    alpha_inv  = ALPHA_ONE - {1'b0, alpha};
    prod_fresh = alpha * mag;
    prod_old   = alpha_inv * avg_q;
    sum        = SUM_W'({prod_fresh, {FRAC_W{1'b0}}}) + SUM_W'(prod_old);
    avg_d      = sum[ALPHA_BITS +: AVG_W];
    last_d     = sample_i;
    raw_o      = avg_d > {threshold_i, {FRAC_W{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      avg_q  <= '0;
    end else if (step_i) begin
      last_q <= last_d;
      avg_q  <= avg_d;
    end
  end

endmodule
`default_nettype wire

>>> src/sde_merge.sv
`default_nettype none
module sde_merge (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              step_i,
  input  wire logic [sde_pkg::NUM_AXES-1:0]      raw_i,
  input  wire logic [sde_pkg::TIME_W-1:0]        now_i,
  input  wire logic [sde_pkg::CFG_W-1:0]         hold_i,
  output sde_pkg::sde_result_t                   result_o
);
  import sde_pkg::*;

  logic              active_q, active_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic [TIME_W-1:0] elapsed;
  logic              any;
  logic              held;

  always_comb begin
    any      = |raw_i;
    active_d = any;
    start_d  = (any && !active_q) ? now_i : start_q;
    elapsed  = now_i - start_d;
    held     = elapsed > TIME_W'(hold_i);
    result_o.shaken_x   = raw_i[0] && held;
    result_o.shaken_y   = raw_i[1] && held;
    result_o.shaken_z   = raw_i[2] && held;
    result_o.shaken_any = any && held;
    result_o.raw_any    = any;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      start_q  <= '0;
    end else if (step_i) begin
      active_q <= active_d;
      start_q  <= start_d;
    end
  end

endmodule
`default_nettype wire

>>> src/shake_detector_ema_core.sv
// shake detector with per-axis exponential moving average
//
// input channel: in_valid_i / in_ready_o carry one request of three signed
// accelerometer samples and a millisecond timestamp. output channel:
// out_valid_o / out_ready_i carry the five shake flags for that request.
// configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0..2 alpha, 3..5 threshold, 6 hold time); other indexes are ignored.
//
// three axis lanes update their averages side by side in the accept cycle,
// a merge stage tracks the shake start time, and the flags land in an
// output register. out_valid_o rises in the cycle after accept, and one
// request is taken every cycle while the receiver keeps up. a new request
// is accepted in the same cycle the held result is taken; while the receiver
// stalls the result holds and in_ready_o is low. reset clears samples,
// averages and shake state and loads the default register values.
`default_nettype none
module shake_detector_ema_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sde_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [sde_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [15:0]            acc_x_i,
  input  wire logic signed [15:0]            acc_y_i,
  input  wire logic signed [15:0]            acc_z_i,
  input  wire logic [31:0]                   now_ms_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               shaken_x_o,
  output logic                               shaken_y_o,
  output logic                               shaken_z_o,
  output logic                               shaken_any_o,
  output logic                               raw_any_o
);
  import sde_pkg::*;

  logic [CFG_W-1:0]       alpha_q [NUM_AXES];
  logic [CFG_W-1:0]       thr_q   [NUM_AXES];
  logic [CFG_W-1:0]       hold_q;
  logic [SAMPLE_BITS-1:0] sample  [NUM_AXES];
  logic [NUM_AXES-1:0]    raw;
  logic                   step;
  sde_result_t            result;
  sde_result_t            result_q;
  logic                   out_valid_q, out_valid_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  assign sample[0] = acc_x_i[SAMPLE_BITS-1:0];
  assign sample[1] = acc_y_i[SAMPLE_BITS-1:0];
  assign sample[2] = acc_z_i[SAMPLE_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q[0] <= ALPHA_RESET;
      alpha_q[1] <= ALPHA_RESET;
      alpha_q[2] <= ALPHA_RESET;
      thr_q[0]   <= THRESHOLD_RESET;
      thr_q[1]   <= THRESHOLD_RESET;
      thr_q[2]   <= THRESHOLD_RESET;
      hold_q     <= HOLD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ALPHA_X:     alpha_q[0] <= cfg_data_i;
        CFG_ALPHA_Y:     alpha_q[1] <= cfg_data_i;
        CFG_ALPHA_Z:     alpha_q[2] <= cfg_data_i;
        CFG_THRESHOLD_X: thr_q[0]   <= cfg_data_i;
        CFG_THRESHOLD_Y: thr_q[1]   <= cfg_data_i;
        CFG_THRESHOLD_Z: thr_q[2]   <= cfg_data_i;
        CFG_HOLD:        hold_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    sde_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (step),
      .sample_i    (sample[g]),
      .alpha_i     (alpha_q[g]),
      .threshold_i (thr_q[g]),
      .raw_o       (raw[g])
    );
  end

  sde_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .raw_i    (raw),
    .now_i    (now_ms_i),
    .hold_i   (hold_q),
    .result_o (result)
  );

  assign out_valid_d = step || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign shaken_x_o   = result_q.shaken_x;
  assign shaken_y_o   = result_q.shaken_y;
  assign shaken_z_o   = result_q.shaken_z;
  assign shaken_any_o = result_q.shaken_any;
  assign raw_any_o    = result_q.raw_any;

endmodule
`default_nettype wire
